/* src/load_instruction_emulator_core_defines.svh */
// Assertion macros for the load instruction emulator core
`ifndef LOAD_INSTRUCTION_EMULATOR_CORE_DEFINES_SVH
`define LOAD_INSTRUCTION_EMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define LIE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lie assertion failed");

// next-cycle implication
`define LIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lie assertion failed");

`endif

/* src/lie_pkg.sv */
// Types and constants shared by the load instruction emulator core
`default_nettype none
package lie_pkg;

  localparam int unsigned XLEN    = 64;
  localparam int unsigned GPR_AW  = 5;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned NUM_GPR = 31;

  localparam logic [GPR_AW-1:0] REG_ZR     = 5'd31;
  localparam logic [IDX_W-1:0]  REG_SP_IDX = 6'd31;
  localparam logic [IDX_W-1:0]  REG_PC_IDX = 6'd32;

  localparam logic [31:0] LDRB_UIMM_MASK  = 32'hffc00000;
  localparam logic [31:0] LDRB_UIMM_MATCH = 32'h39400000;
  localparam logic [31:0] LDRB_IDX_MASK   = 32'hffc00400;
  localparam logic [31:0] LDRB_IDX_MATCH  = 32'h38400400;
  localparam logic [31:0] LDP_MASK        = 32'hfe400000;
  localparam logic [31:0] LDP_MATCH       = 32'ha8400000;
  localparam logic [31:0] LDURB_MASK      = 32'hffe00c00;
  localparam logic [31:0] LDURB_MATCH     = 32'h38400000;
  localparam logic [31:0] BIT_PREINDEX    = 32'h00000800;
  localparam logic [31:0] BIT_PAIR_NOPOST = 32'h01000000;
  localparam logic [31:0] BIT_PAIR_WB     = 32'h00800000;

  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } lie_op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_MISMATCH = 2'd2
  } lie_status_e;

  // register file writes, port 2 wins over port 1 wins over port 0
  typedef struct packed {
    logic              we0;
    logic [GPR_AW-1:0] addr0;
    logic [XLEN-1:0]   data0;
    logic              we1;
    logic [GPR_AW-1:0] addr1;
    logic [XLEN-1:0]   data1;
    logic              we2;
    logic [GPR_AW-1:0] addr2;
    logic [XLEN-1:0]   data2;
    logic              sp_we;
    logic [XLEN-1:0]   sp_data;
    logic              pc_we;
    logic [XLEN-1:0]   pc_data;
  } lie_wr_t;

endpackage
`default_nettype wire

/* src/lie_regfile.sv */
// Flop register file: general registers, stack pointer and program counter
`default_nettype none
module lie_regfile import lie_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lie_wr_t          wr_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [XLEN-1:0]  rd_data_o,
  output logic [XLEN-1:0]  pc_o
);

  logic [XLEN-1:0] gpr_q [NUM_GPR];
  logic [XLEN-1:0] sp_q;
  logic [XLEN-1:0] pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GPR; i++) begin
        gpr_q[i] <= '0;
      end
      sp_q <= '0;
      pc_q <= '0;
    end else begin
      for (int i = 0; i < NUM_GPR; i++) begin
        if (wr_i.we2 && wr_i.addr2 == GPR_AW'(i)) begin
          gpr_q[i] <= wr_i.data2;
        end else if (wr_i.we1 && wr_i.addr1 == GPR_AW'(i)) begin
          gpr_q[i] <= wr_i.data1;
        end else if (wr_i.we0 && wr_i.addr0 == GPR_AW'(i)) begin
          gpr_q[i] <= wr_i.data0;
        end
      end
      if (wr_i.sp_we) begin
        sp_q <= wr_i.sp_data;
      end
      if (wr_i.pc_we) begin
        pc_q <= wr_i.pc_data;
      end
    end
  end

  always_comb begin
    if (rd_idx_i < REG_SP_IDX) begin
      rd_data_o = gpr_q[rd_idx_i[GPR_AW-1:0]];
    end else if (rd_idx_i == REG_SP_IDX) begin
      rd_data_o = sp_q;
    end else if (rd_idx_i == REG_PC_IDX) begin
      rd_data_o = pc_q;
    end else begin
      rd_data_o = '0;
    end
  end

  assign pc_o = pc_q;

endmodule
`default_nettype wire

/* src/lie_exec.sv */
// Load decode, address check and register write generation
`default_nettype none
module lie_exec import lie_pkg::*; (
  input  logic [31:0]     instr_i,
  input  logic [XLEN-1:0] fault_i,
  input  logic [XLEN-1:0] lo_i,
  input  logic [XLEN-1:0] hi_i,
  input  logic [XLEN-1:0] base_i,
  input  logic [XLEN-1:0] pc_i,
  output lie_status_e     status_o,
  output lie_wr_t         wr_o
);

  logic [GPR_AW-1:0] rt, rn, rt2;
  logic              known, pair, wb, post, match;
  logic [XLEN-1:0]   off, sum, addr;

  assign rt  = instr_i[4:0];
  assign rn  = instr_i[9:5];
  assign rt2 = instr_i[14:10];

  always_comb begin
    known = 1'b0;
    pair  = 1'b0;
    wb    = 1'b0;
    post  = 1'b0;
    off   = '0;
    if ((instr_i & LDRB_UIMM_MASK) == LDRB_UIMM_MATCH) begin
      known = 1'b1;
      off   = {52'b0, instr_i[21:10]};
    end else if ((instr_i & LDRB_IDX_MASK) == LDRB_IDX_MATCH) begin
      known = 1'b1;
      wb    = 1'b1;
      post  = (instr_i & BIT_PREINDEX) == '0;
      off   = {{55{instr_i[20]}}, instr_i[20:12]};
    end else if ((instr_i & LDP_MASK) == LDP_MATCH) begin
      pair  = 1'b1;
      wb    = (instr_i & BIT_PAIR_WB) != '0;
      post  = (instr_i & BIT_PAIR_NOPOST) == '0;
      known = wb || !post;
      off   = {{54{instr_i[21]}}, instr_i[21:15], 3'b000};
    end else if ((instr_i & LDURB_MASK) == LDURB_MATCH) begin
      known = 1'b1;
      off   = {{55{instr_i[20]}}, instr_i[20:12]};
    end
  end

  // post-index checks the plain base; writeback is always base + offset
  assign sum   = base_i + off;
  assign addr  = post ? base_i : sum;
  assign match = addr == fault_i;

  always_comb begin
    wr_o = '0;
    if (!known) begin
      status_o = ST_UNKNOWN;
    end else if (!match) begin
      status_o = ST_MISMATCH;
    end else begin
      status_o   = ST_DONE;
      wr_o.we0   = rt != REG_ZR;
      wr_o.addr0 = rt;
      wr_o.data0 = pair ? lo_i : {56'b0, lo_i[7:0]};
      if (wb) begin
        if (rn == REG_ZR) begin
          wr_o.sp_we   = 1'b1;
          wr_o.sp_data = sum;
        end else begin
          wr_o.we1   = 1'b1;
          wr_o.addr1 = rn;
          wr_o.data1 = sum;
        end
      end
      wr_o.we2     = pair && (rt2 != REG_ZR);
      wr_o.addr2   = rt2;
      wr_o.data2   = hi_i;
      wr_o.pc_we   = 1'b1;
      wr_o.pc_data = pc_i + 64'd4;
    end
  end

endmodule
`default_nettype wire

/* src/load_instruction_emulator_core.sv */
// Load instruction emulator core: top level with input and result registers
// Path: input register, then result register, from input transfer to result valid.
// Throughput: one item per cycle unless the output stalls; state updates at the
// edge loading the result, so the next item in the input register sees them.
// Reset: async active low; clears valid flags, all general registers, SP and PC.
`default_nettype none
module load_instruction_emulator_core import lie_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] instruction, [95:32] fault_address, [159:96] data_low,
  // [223:160] data_high, [229:224] reg_index, [293:230] reg_value, [295:294] zero
  input  logic [295:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [63:0] read_value
  output logic [63:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]   m_axis_tuser_o
);

  logic              in_valid_q;
  lie_op_e           in_op_q;
  logic [31:0]       in_instr_q;
  logic [XLEN-1:0]   in_fault_q, in_lo_q, in_hi_q, in_value_q;
  logic [IDX_W-1:0]  in_idx_q;

  logic              out_valid_q;
  lie_status_e       out_status_q, out_status_d;
  logic [XLEN-1:0]   out_value_q, out_value_d;

  logic              adv, fire;
  logic [IDX_W-1:0]  rd_idx;
  logic [XLEN-1:0]   rd_data, pc;
  lie_status_e       ex_status;
  lie_wr_t           ex_wr, reg_wr, wr;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && adv;
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q    <= lie_op_e'(s_axis_tuser_i);
      in_instr_q <= s_axis_tdata_i[31:0];
      in_fault_q <= s_axis_tdata_i[95:32];
      in_lo_q    <= s_axis_tdata_i[159:96];
      in_hi_q    <= s_axis_tdata_i[223:160];
      in_idx_q   <= s_axis_tdata_i[229:224];
      in_value_q <= s_axis_tdata_i[293:230];
    end
  end

  assign rd_idx = (in_op_q == OP_READ) ? in_idx_q : {1'b0, in_instr_q[9:5]};

  lie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .pc_o      (pc)
  );

  lie_exec u_exec (
    .instr_i  (in_instr_q),
    .fault_i  (in_fault_q),
    .lo_i     (in_lo_q),
    .hi_i     (in_hi_q),
    .base_i   (rd_data),
    .pc_i     (pc),
    .status_o (ex_status),
    .wr_o     (ex_wr)
  );

  always_comb begin
    reg_wr = '0;
    if (in_idx_q < REG_SP_IDX) begin
      reg_wr.we0   = 1'b1;
      reg_wr.addr0 = in_idx_q[GPR_AW-1:0];
      reg_wr.data0 = in_value_q;
    end else if (in_idx_q == REG_SP_IDX) begin
      reg_wr.sp_we   = 1'b1;
      reg_wr.sp_data = in_value_q;
    end else if (in_idx_q == REG_PC_IDX) begin
      reg_wr.pc_we   = 1'b1;
      reg_wr.pc_data = in_value_q;
    end
  end

  always_comb begin
    wr           = '0;
    out_status_d = ST_DONE;
    out_value_d  = '0;
    case (in_op_q)
      OP_EXEC: begin
        out_status_d = ex_status;
        if (fire) begin
          wr = ex_wr;
        end
      end
      OP_WRITE: begin
        if (fire) begin
          wr = reg_wr;
        end
      end
      OP_READ: begin
        out_value_d = rd_data;
      end
      default: begin
        out_status_d = ST_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

`include "load_instruction_emulator_core_defines.svh"

  `LIE_ASSERT_SAME(a_ready_when_empty, !out_valid_q, s_axis_tready_o)
  `LIE_ASSERT_NEXT(a_pc_kept_on_fail, fire && in_op_q == OP_EXEC && ex_status != ST_DONE, pc == $past(pc))
  `LIE_ASSERT_NEXT(a_value_zero_not_read, fire && in_op_q != OP_READ, out_value_q == '0)
  `LIE_ASSERT_NEXT(a_unknown_op, fire && in_op_q == OP_NONE, out_status_q == ST_UNKNOWN)

endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for load_instruction_emulator_core: random load/register streams against a predictor
module tb;
  import lie_pkg::*;

  typedef struct {
    lie_op_e     op;
    logic [31:0] ins;
    logic [63:0] fault;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [5:0]  idx;
    logic [63:0] val;
    bit          drain_first;
  } load_item_t;

  typedef struct {
    lie_status_e status;
    logic [63:0] value;
  } load_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [295:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  load_instruction_emulator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #3000000;
    $display("** load_instruction_emulator_core: FAILED **");
    $finish;
  end

  // mirrored architectural state
  logic [63:0]  gpr_mirror [NUM_GPR];
  logic [63:0]  sp_mirror = '0;
  logic [63:0]  pc_mirror = '0;

  load_item_t   pending_items[$];
  load_result_t expected_results[$];
  load_item_t   cur_item;
  bit           offering = 1'b0;
  bit           drain_next = 1'b0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           n_acc = 0;
  int           n_rcv = 0;
  int           sent_cnt = 0;
  int           recv_cnt = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  int           err_cnt = 0;
  int           queued = 0;

  initial begin
    foreach (gpr_mirror[i]) gpr_mirror[i] = '0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_cnt < 40) begin
      $display("MISMATCH transfer %0d: %s got %h want %h", n_rcv, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_wait(input int n);
    if ((n / 150) % 4 == 2) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
  endfunction

  // returns 0 for encodings that are not emulated
  function automatic bit decode_form(input logic [31:0] ins, output bit pair, output bit wb,
                                     output bit post, output logic [63:0] off);
    pair = 1'b0;
    wb = 1'b0;
    post = 1'b0;
    off = '0;
    if ((ins & LDRB_UIMM_MASK) == LDRB_UIMM_MATCH) begin
      off = {52'd0, ins[21:10]};
    end else if ((ins & LDRB_IDX_MASK) == LDRB_IDX_MATCH) begin
      wb = 1'b1;
      post = (ins & BIT_PREINDEX) == '0;
      off = {{55{ins[20]}}, ins[20:12]};
    end else if ((ins & LDP_MASK) == LDP_MATCH) begin
      pair = 1'b1;
      wb = (ins & BIT_PAIR_WB) != '0;
      post = (ins & BIT_PAIR_NOPOST) == '0;
      off = {{54{ins[21]}}, ins[21:15], 3'b000};
      if (!wb && post) return 1'b0;
    end else if ((ins & LDURB_MASK) == LDURB_MATCH) begin
      off = {{55{ins[20]}}, ins[20:12]};
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic lie_status_e run_load(input load_item_t it);
    bit          pair, wb, post;
    logic [63:0] off, addr, wb_val;
    logic [4:0]  rt, rn, rt2;
    rt = it.ins[4:0];
    rn = it.ins[9:5];
    rt2 = it.ins[14:10];
    if (!decode_form(it.ins, pair, wb, post, off)) return ST_UNKNOWN;
    addr = (rn == REG_ZR) ? sp_mirror : gpr_mirror[rn];
    if (!post) addr += off;
    if (addr != it.fault) return ST_MISMATCH;
    wb_val = post ? addr + off : addr;
    if (rt != REG_ZR) gpr_mirror[rt] = pair ? it.lo : {56'd0, it.lo[7:0]};
    if (wb) begin
      if (rn == REG_ZR) sp_mirror = wb_val;
      else gpr_mirror[rn] = wb_val;
    end
    if (pair && rt2 != REG_ZR) gpr_mirror[rt2] = it.hi;
    pc_mirror += 64'd4;
    return ST_DONE;
  endfunction

  function automatic void emulate_item(input load_item_t it);
    load_result_t r;
    r.status = ST_DONE;
    r.value = '0;
    case (it.op)
      OP_EXEC: begin
        r.status = run_load(it);
      end
      OP_WRITE: begin
        if (it.idx < REG_SP_IDX) gpr_mirror[it.idx[4:0]] = it.val;
        else if (it.idx == REG_SP_IDX) sp_mirror = it.val;
        else if (it.idx == REG_PC_IDX) pc_mirror = it.val;
      end
      OP_READ: begin
        if (it.idx < REG_SP_IDX) r.value = gpr_mirror[it.idx[4:0]];
        else if (it.idx == REG_SP_IDX) r.value = sp_mirror;
        else if (it.idx == REG_PC_IDX) r.value = pc_mirror;
      end
      default: begin
        r.status = ST_UNKNOWN;
      end
    endcase
    expected_results.push_back(r);
  endfunction

  task automatic push_item(input load_item_t it);
    it.drain_first = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(it);
    queued++;
  endtask

  // unused fields carry random bits
  task automatic add_reg_op(input lie_op_e op, input logic [5:0] idx, input logic [63:0] val);
    load_item_t it;
    it.op = op;
    it.ins = $urandom;
    it.fault = rand64();
    it.lo = rand64();
    it.hi = rand64();
    it.idx = idx;
    it.val = val;
    push_item(it);
  endtask

  task automatic add_exec(input logic [31:0] ins, input logic [63:0] fault);
    load_item_t it;
    it.op = OP_EXEC;
    it.ins = ins;
    it.fault = fault;
    it.lo = rand64();
    it.hi = rand64();
    it.idx = 6'($urandom);
    it.val = rand64();
    push_item(it);
  endtask

  // base set up, then a load whose fault address normally matches
  // form: 0 uimm byte, 1 indexed byte, 2 pair, 3 unscaled byte, 4 pair with index bits 00
  task automatic add_load_seq(input int form);
    logic [63:0] base, off, fault;
    logic [31:0] ins;
    logic [4:0]  rn, rt;
    bit          pair, wb, post;
    rn = 5'($urandom_range(0, 31));
    rt = ($urandom_range(0, 4) == 0) ? rn : 5'($urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = '1;
      default: base = rand64();
    endcase
    add_reg_op(OP_WRITE, {1'b0, rn}, base);
    case (form)
      0: ins = LDRB_UIMM_MATCH | ($urandom & ~LDRB_UIMM_MASK);
      1: ins = LDRB_IDX_MATCH | ($urandom & ~LDRB_IDX_MASK);
      2: ins = LDP_MATCH | ($urandom & ~LDP_MASK);
      3: ins = LDURB_MATCH | ($urandom & ~LDURB_MASK);
      default: ins = (LDP_MATCH | ($urandom & ~LDP_MASK)) & ~(BIT_PAIR_NOPOST | BIT_PAIR_WB);
    endcase
    ins[9:5] = rn;
    ins[4:0] = rt;
    if (form == 2 && $urandom_range(0, 3) == 0) ins[14:10] = $urandom_range(0, 1) ? rn : rt;
    void'(decode_form(ins, pair, wb, post, off));
    fault = post ? base : base + off;
    if ($urandom_range(0, 7) == 0) fault ^= 64'd1 << $urandom_range(0, 63);
    add_exec(ins, fault);
    if ($urandom_range(0, 1)) add_reg_op(OP_READ, {1'b0, rt}, rand64());
    if ($urandom_range(0, 1)) add_reg_op(OP_READ, {1'b0, rn}, rand64());
    if (form == 2 && $urandom_range(0, 1)) add_reg_op(OP_READ, {1'b0, ins[14:10]}, rand64());
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        emulate_item(cur_item);
        n_acc++;
        offering = 1'b0;
        tx_gap = pick_wait(n_acc);
      end
      if (!offering) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain_first && recv_cnt != n_acc)) begin
          cur_item = pending_items.pop_front();
          offering = 1'b1;
          // {pad, reg_value, reg_index, data_high, data_low, fault_address, instruction}
          s_axis_tdata_i <= {2'b00, cur_item.val, cur_item.idx, cur_item.hi, cur_item.lo,
                             cur_item.fault, cur_item.ins};
          s_axis_tuser_i <= cur_item.op;
        end
      end
      s_axis_tvalid_i <= offering;
      sent_cnt <= n_acc;
    end
  end

  // one long receiver hold-off while the sender keeps going
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= 400) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    load_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, read_value", m_axis_tdata_o, '0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser_o !== want.status) begin
            report_mismatch("status", 64'(m_axis_tuser_o), 64'(want.status));
          end
          if (m_axis_tdata_o !== want.value) begin
            report_mismatch("read_value", m_axis_tdata_o, want.value);
          end
        end
        n_rcv++;
        rx_gap = pick_wait(n_rcv);
      end else if (rx_gap != 0) begin
        rx_gap--;
      end
      m_axis_tready_i <= (rx_gap == 0) && (hold_left == 0);
      recv_cnt <= n_rcv;
    end
  end

  initial begin
    int          target;
    logic [5:0]  idx;
    // directed
    add_reg_op(OP_READ, 6'd0, '0);
    add_reg_op(OP_READ, REG_SP_IDX, '0);
    add_reg_op(OP_READ, REG_PC_IDX, '0);
    add_reg_op(OP_WRITE, 6'd30, '1);
    add_reg_op(OP_READ, 6'd30, '0);
    add_reg_op(OP_WRITE, 6'd63, '1);
    add_reg_op(OP_READ, 6'd63, '0);
    add_reg_op(OP_NONE, 6'd0, '1);
    add_reg_op(OP_WRITE, REG_PC_IDX, 64'hffff_ffff_ffff_fffc);
    add_exec(32'h0000_0000, '0);
    add_exec(32'hffff_ffff, '1);
    for (int f = 0; f < 5; f++) add_load_seq(f);
    add_reg_op(OP_READ, REG_PC_IDX, '0);
    drain_next = 1'b1;
    // random
    target = queued + 1100;
    while (queued < target) begin
      if (queued > target - 400 && queued < target - 390) drain_next = 1'b1;
      idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 32));
      case ($urandom_range(0, 11))
        7: add_reg_op(OP_WRITE, idx, rand64());
        8: add_reg_op(OP_READ, idx, rand64());
        9: add_exec($urandom, rand64());
        10: add_exec(LDP_MATCH | ($urandom & ~LDP_MASK), rand64());
        11: add_reg_op(lie_op_e'($urandom_range(0, 3)), idx, rand64());
        default: add_load_seq($urandom_range(0, 4));
      endcase
    end
    while (pending_items.size() != 0 || offering || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("results outstanding", 64'(expected_results.size()), '0);
    end
    if (err_cnt == 0) begin
      $display("** load_instruction_emulator_core: PASSED **");
    end else begin
      $display("** load_instruction_emulator_core: FAILED **");
    end
    $finish;
  end

endmodule
